### rtl/core/osc_pkg.sv
// osc_pkg: shared types and constants for the open subpath closer
// path element codes, coordinate width and the word structs of both channels
// no dependencies
`default_nettype none

package osc_pkg;

  // coordinate width, signed fixed point (16.16 at the default of 32)
  localparam int unsigned COORD_W = 32;
  localparam int unsigned TOL_W   = 16;

  // path element codes
  localparam logic [1:0] CODE_MOVE = 2'd0;
  localparam logic [1:0] CODE_OPEN = 2'd1;
  localparam logic [1:0] CODE_LINE = 2'd2;
  localparam logic [1:0] CODE_END  = 2'd3;

  typedef struct packed {
    logic [1:0]                path_code;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                out_code;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      inserted_close;
    logic                      last_of_run;
  } out_word_t;

  // what one processed element produces: an optional closing line, then the main word
  typedef struct packed {
    logic      has_close;
    out_word_t close_w;
    out_word_t main_w;
  } step_res_t;

endpackage

`default_nettype wire

### rtl/core/osc_step.sv
// osc_step: subpath state, tolerance register and per-element close decision
// depends on osc_pkg
`default_nettype none

module osc_step (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         take_i,
  input  wire osc_pkg::in_word_t            word_i,
  input  wire logic                         tol_we_i,
  input  wire logic [osc_pkg::TOL_W-1:0]    tol_wdata_i,
  output osc_pkg::step_res_t                res_o
);

  localparam int unsigned DW = osc_pkg::COORD_W + 1;

  logic [osc_pkg::TOL_W-1:0]          tol_q;
  logic signed [osc_pkg::COORD_W-1:0] start_x_q, start_x_d;
  logic signed [osc_pkg::COORD_W-1:0] start_y_q, start_y_d;
  logic signed [osc_pkg::COORD_W-1:0] prev_x_q, prev_x_d;
  logic signed [osc_pkg::COORD_W-1:0] prev_y_q, prev_y_d;
  logic [1:0]                         prev_code_q, prev_code_d;
  logic                               open_q, open_d;
  logic                               have_prev_q, have_prev_d;

  logic signed [DW-1:0] dx, dy, tol_pos, tol_neg;
  logic                 gap_x, gap_y, test, need_close;

  // exact signed gap per axis against +/- tolerance
  assign dx      = DW'(start_x_q) - DW'(prev_x_q);
  assign dy      = DW'(start_y_q) - DW'(prev_y_q);
  assign tol_pos = signed'(DW'(tol_q));
  assign tol_neg = -tol_pos;
  assign gap_x   = (dx > tol_pos) || (dx < tol_neg);
  assign gap_y   = (dy > tol_pos) || (dy < tol_neg);

  // boundary test skipped with no previous element, after an open move and before a line
  assign test       = have_prev_q && (prev_code_q != osc_pkg::CODE_OPEN)
                      && (word_i.path_code != osc_pkg::CODE_LINE);
  assign need_close = test && open_q && (gap_x || gap_y);

  always_comb begin
    res_o.has_close              = need_close;
    res_o.close_w.out_code       = osc_pkg::CODE_LINE;
    res_o.close_w.out_x          = start_x_q;
    res_o.close_w.out_y          = start_y_q;
    res_o.close_w.inserted_close = 1'b1;
    res_o.close_w.last_of_run    = 1'b0;
    res_o.main_w.inserted_close  = 1'b0;
    res_o.main_w.last_of_run     = 1'b1;
    if (word_i.path_code == osc_pkg::CODE_END) begin
      res_o.main_w.out_code = osc_pkg::CODE_END;
      res_o.main_w.out_x    = '0;
      res_o.main_w.out_y    = '0;
    end else begin
      res_o.main_w.out_code = (word_i.path_code == osc_pkg::CODE_OPEN) ?
                              osc_pkg::CODE_MOVE : word_i.path_code;
      res_o.main_w.out_x    = word_i.point_x;
      res_o.main_w.out_y    = word_i.point_y;
    end
  end

  always_comb begin
    start_x_d   = start_x_q;
    start_y_d   = start_y_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    prev_code_d = prev_code_q;
    open_d      = open_q;
    have_prev_d = have_prev_q;
    if (take_i) begin
      if (test) begin
        open_d = 1'b0;
      end
      if (word_i.path_code == osc_pkg::CODE_END) begin
        start_x_d   = '0;
        start_y_d   = '0;
        prev_x_d    = '0;
        prev_y_d    = '0;
        prev_code_d = osc_pkg::CODE_END;
        open_d      = 1'b0;
        have_prev_d = 1'b0;
      end else begin
        if (word_i.path_code == osc_pkg::CODE_OPEN) begin
          start_x_d = word_i.point_x;
          start_y_d = word_i.point_y;
          open_d    = 1'b1;
        end
        prev_code_d = word_i.path_code;
        prev_x_d    = word_i.point_x;
        prev_y_d    = word_i.point_y;
        have_prev_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= '0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_code_q <= osc_pkg::CODE_END;
      open_q      <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      if (tol_we_i) begin
        tol_q <= tol_wdata_i;
      end
      start_x_q   <= start_x_d;
      start_y_q   <= start_y_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      prev_code_q <= prev_code_d;
      open_q      <= open_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/osc_out.sv
// osc_out: result register plus one hold slot for the word behind an inserted close
// depends on osc_pkg
`default_nettype none

module osc_out (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire osc_pkg::step_res_t  res_i,
  output logic                     space_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output osc_pkg::out_word_t       out_word_o
);

  logic               out_vld_q, out_vld_d;
  logic               hold_vld_q, hold_vld_d;
  osc_pkg::out_word_t out_q, out_d;
  osc_pkg::out_word_t hold_q, hold_d;
  logic               out_free;

  assign out_free = !out_vld_q || !out_stall_i;
  assign space_o  = out_free && !hold_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    hold_vld_d = hold_vld_q;
    out_d      = out_q;
    hold_d     = hold_q;
    if (out_free) begin
      if (hold_vld_q) begin
        out_d      = hold_q;
        out_vld_d  = 1'b1;
        hold_vld_d = 1'b0;
      end else if (push_i) begin
        out_vld_d = 1'b1;
        if (res_i.has_close) begin
          out_d      = res_i.close_w;
          hold_d     = res_i.main_w;
          hold_vld_d = 1'b1;
        end else begin
          out_d = res_i.main_w;
        end
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/open_subpath_closer_unit.sv
// open_subpath_closer_unit: top level of the open subpath closer
// instantiates osc_step and osc_out, uses osc_pkg
//
//   channel   direction  handshake                 word
//   in        input      in_valid_i / in_stall_o   osc_pkg::in_word_t
//   out       output     out_valid_o / out_stall_i osc_pkg::out_word_t
//   cfg       input      cfg_we_i                  close_tolerance, 16 bit
//
// input register, one level of compares, result register; one element per cycle
// while out_stall_i is low and no close is inserted; an element needing a closing
// line puts out the close, then the element itself, which waits in the hold slot
// the first result word is registered as the element leaves the input register
// reset clears the subpath state, the tolerance and all valid flags
// out_stall_i on a valid result holds the element in the input register and
// raises in_stall_o in the same cycle
`default_nettype none

module open_subpath_closer_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire osc_pkg::in_word_t          in_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output osc_pkg::out_word_t              out_word_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [osc_pkg::TOL_W-1:0]  cfg_wdata_i
);

  // input register
  logic              in_vld_q, in_vld_d;
  osc_pkg::in_word_t in_q;
  logic              in_acc;

  // step control
  logic               take;
  logic               space;
  osc_pkg::step_res_t res;

  // element in the input register is processed when the output side has room
  assign take       = in_vld_q && space;
  assign in_stall_o = in_vld_q && !take;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (take) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_word_i;
    end
  end

  // subpath state and close decision
  osc_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .word_i      (in_q),
    .tol_we_i    (cfg_we_i),
    .tol_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  // result register and hold slot
  osc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
